// ----- rtl/avag_pkg.sv -----
// Shared types, constants and coefficient tables for the VAG ADPCM stream decoder.
`default_nettype none

package avag_pkg;

	// Fixed-point format of the predictor history
	localparam int HISTORY_FRAC_BITS = 6;
	localparam int COEF_FRAC_BITS    = 6;

	// Field and datapath widths
	localparam int BYTE_W   = 8;
	localparam int NIB_W    = 4;
	localparam int COUNT_W  = 24;
	localparam int IDX_W    = 4;
	localparam int HIST_W   = 32;
	localparam int COEF_W   = 8;
	localparam int RAW_W    = 16;
	localparam int PROD_W   = HIST_W + COEF_W;
	localparam int SAMPLE_W = 16;

	// Stream layout
	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
	localparam int                 SKIP_BYTES = 16;
	localparam logic [IDX_W-1:0]   HDR_IDX    = 4'd0;
	localparam logic [IDX_W-1:0]   FLAGS_IDX  = 4'd1;
	localparam logic [IDX_W-1:0]   LAST_IDX   = 4'd15;

	// Flag byte codes
	localparam logic [BYTE_W-1:0] FLAG_LOOP_END = 8'd1;
	localparam logic [BYTE_W-1:0] FLAG_FINAL    = 8'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic load_byte;
		logic clear_hist;
		logic load_hdr;
		logic nib_sel;
		logic mul_en;
		logic acc_en;
		logic emit_sample;
		logic emit_end;
		logic last;
	} avag_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} avag_sts_t;

	// First predictor tap in 64ths; filters above four give zero
	function automatic logic signed [COEF_W-1:0] coef_a(input logic [NIB_W-1:0] filt);
		logic signed [COEF_W-1:0] k;
		case (filt)
			4'd1:    k = 8'sd60;
			4'd2:    k = 8'sd115;
			4'd3:    k = 8'sd98;
			4'd4:    k = 8'sd122;
			default: k = 8'sd0;
		endcase
		return k;
	endfunction

	// Second predictor tap in 64ths
	function automatic logic signed [COEF_W-1:0] coef_b(input logic [NIB_W-1:0] filt);
		logic signed [COEF_W-1:0] k;
		case (filt)
			4'd2:    k = -8'sd52;
			4'd3:    k = -8'sd55;
			4'd4:    k = -8'sd60;
			default: k = 8'sd0;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/avag_ctrl.sv -----
// Parse controller: stream byte counting, block framing, end detection and sequencing.
`default_nettype none

module avag_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [avag_pkg::BYTE_W-1:0]    data_byte,
	input  wire logic                           stream_start,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [avag_pkg::COUNT_W-1:0]   cfg_data,
	output avag_pkg::avag_cmd_t                 cmd,
	input  wire avag_pkg::avag_sts_t            sts
);
	import avag_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_EMIT, S_END} state_t;

	localparam logic [COUNT_W-1:0] SKIP_CNT   = COUNT_W'(SKIP_BYTES);
	localparam logic [COUNT_W:0]   LEN_MARGIN = (COUNT_W+1)'(SKIP_BYTES - 1);

	state_t               state_q;
	logic [COUNT_W-1:0]   count_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 end_pend_q;
	logic                 final_q;
	logic                 stopped_q;
	logic                 last_pend_q;
	logic                 nib_q;
	logic [COUNT_W-1:0]   src_len_q;

	logic                 in_accept;
	logic [COUNT_W-1:0]   eff_count;
	logic [IDX_W-1:0]     eff_idx;
	logic                 eff_end, eff_final, eff_stopped;
	logic                 active, is_hdr, is_flags, is_data;
	logic                 flag_end, len_hit, stop;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;

	// Parse state as seen by this byte (a stream start restarts it)
	always_comb begin
		eff_count   = stream_start ? '0 : count_q;
		eff_idx     = stream_start ? '0 : idx_q;
		eff_end     = stream_start ? 1'b0 : end_pend_q;
		eff_final   = stream_start ? 1'b0 : final_q;
		eff_stopped = stream_start ? 1'b0 : stopped_q;
		active      = !eff_stopped && (eff_count >= SKIP_CNT);
		is_hdr      = active && (eff_idx == HDR_IDX);
		is_flags    = active && (eff_idx == FLAGS_IDX);
		is_data     = active && !is_hdr && !is_flags;
		flag_end    = (data_byte == FLAG_LOOP_END) || (data_byte == FLAG_FINAL);
		len_hit     = ({1'b0, eff_count} + LEN_MARGIN) >= {1'b0, src_len_q};
		stop        = eff_end || len_hit;
	end

	// Datapath commands
	always_comb begin
		cmd.load_byte   = in_accept;
		cmd.clear_hist  = in_accept && stream_start;
		cmd.load_hdr    = in_accept && is_hdr;
		cmd.nib_sel     = nib_q;
		cmd.mul_en      = (state_q == S_MUL);
		cmd.acc_en      = (state_q == S_ACC);
		cmd.emit_sample = (state_q == S_EMIT) && sts.out_free;
		cmd.emit_end    = (state_q == S_END) && sts.out_free;
		cmd.last        = (state_q == S_END) || (nib_q && last_pend_q);
	end

	// State and parse registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			end_pend_q  <= 1'b0;
			final_q     <= 1'b0;
			stopped_q   <= 1'b0;
			last_pend_q <= 1'b0;
			nib_q       <= 1'b0;
			src_len_q   <= COUNT_MAX;
		end else begin
			if (cfg_valid && cfg_ready) begin
				src_len_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						count_q     <= eff_count + COUNT_W'(!eff_stopped && (eff_count != COUNT_MAX));
						idx_q       <= active ? eff_idx + 4'd1 : eff_idx;
						end_pend_q  <= eff_end || (is_flags && flag_end);
						final_q     <= is_flags ? (data_byte == FLAG_FINAL) : eff_final;
						stopped_q   <= eff_stopped || (is_flags && stop)
							|| (is_data && (eff_idx == LAST_IDX) && eff_final);
						last_pend_q <= (eff_idx == LAST_IDX) && eff_final;
						nib_q       <= 1'b0;
						if (is_flags && stop) begin
							state_q <= S_END;
						end else if (is_data) begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (sts.out_free) begin
						if (nib_q) begin
							state_q <= S_IDLE;
						end else begin
							nib_q   <= 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_END: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A result is only loaded into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sample || cmd.emit_end) |-> sts.out_free)
		else $error("result loaded into a busy output register");

	// Multiply is always followed by accumulate
	a_mul_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |=> (state_q == S_ACC))
		else $error("multiply stage not followed by accumulate");

	// The final result of a stream always leaves the parser stopped
	a_last_stop: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.emit_sample && cmd.last) || cmd.emit_end) |-> stopped_q)
		else $error("final result while parser still running");

	// Only the second nibble of a byte can carry last
	a_last_nib: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sample && cmd.last) |-> nib_q)
		else $error("last flag on first nibble");

endmodule

`default_nettype wire

// ----- rtl/avag_dp.sv -----
// Datapath: header and byte registers, two-tap predictor, history and output register.
`default_nettype none

module avag_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic [avag_pkg::BYTE_W-1:0]          data_byte,
	input  wire avag_pkg::avag_cmd_t                  cmd,
	output avag_pkg::avag_sts_t                       sts,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [avag_pkg::SAMPLE_W-1:0]      pcm_sample,
	output logic                                      has_sample,
	output logic                                      last
);
	import avag_pkg::*;

	localparam int SCALE_SH     = HISTORY_FRAC_BITS + COEF_FRAC_BITS;
	localparam int RAW_SCALED_W = RAW_W + SCALE_SH;
	localparam int ACC_W        = ((RAW_SCALED_W > PROD_W) ? RAW_SCALED_W : PROD_W) + 2;
	localparam int T_W          = HIST_W + 1;

	localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(1 << (COEF_FRAC_BITS - 1));
	localparam logic signed [T_W-1:0]   T_HALF    = T_W'(1 << (HISTORY_FRAC_BITS - 1));
	localparam logic signed [T_W-1:0]   T_BIAS    = T_W'((1 << HISTORY_FRAC_BITS) - 1);
	localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
	localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

	logic [BYTE_W-1:0]              byte_q;
	logic [NIB_W-1:0]               filt_q;
	logic [NIB_W-1:0]               shift_q;
	logic signed [HIST_W-1:0]       prev_q, prev2_q;
	logic signed [RAW_W-1:0]        raw_s1;
	logic signed [PROD_W-1:0]       p0_s1, p1_s1;
	logic                           out_valid_q, has_q, last_q;
	logic signed [SAMPLE_W-1:0]     pcm_q;

	logic [NIB_W-1:0]               nib;
	logic signed [RAW_W-1:0]        raw_w;
	logic signed [COEF_W-1:0]       k0, k1;
	logic signed [ACC_W-1:0]        acc_sum, h_full;
	logic signed [HIST_W-1:0]       h_sat;
	logic                           h_ovf;
	logic signed [T_W-1:0]          t_w, t_adj, d_w;

	// Nibble expansion and coefficient lookup
	always_comb begin
		nib   = cmd.nib_sel ? byte_q[7:4] : byte_q[3:0];
		raw_w = $signed({nib, 12'b0}) >>> shift_q;
		k0    = coef_a(filt_q);
		k1    = coef_b(filt_q);
	end

	// Accumulate, round half up by 64ths, saturate to the history range
	always_comb begin
		acc_sum = (ACC_W'(raw_s1) <<< SCALE_SH) + ACC_W'(p0_s1) + ACC_W'(p1_s1) + ACC_ROUND;
		h_full  = acc_sum >>> COEF_FRAC_BITS;
		h_ovf   = !((&h_full[ACC_W-1:HIST_W-1]) || !(|h_full[ACC_W-1:HIST_W-1]));
		if (h_ovf) begin
			h_sat = h_full[ACC_W-1] ? HIST_MIN : HIST_MAX;
		end else begin
			h_sat = h_full[HIST_W-1:0];
		end
	end

	// Output sample: history plus one half, truncated toward zero
	always_comb begin
		t_w   = T_W'(prev_q) + T_HALF;
		t_adj = t_w + (t_w[T_W-1] ? T_BIAS : '0);
		d_w   = t_adj >>> HISTORY_FRAC_BITS;
	end

	assign sts.out_free = !out_valid_q || !out_stall;

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			byte_q <= data_byte;
		end
		if (cmd.load_hdr) begin
			filt_q  <= data_byte[7:4];
			shift_q <= data_byte[3:0];
		end
		if (cmd.mul_en) begin
			raw_s1 <= raw_w;
			p0_s1  <= PROD_W'(prev_q) * PROD_W'(k0);
			p1_s1  <= PROD_W'(prev2_q) * PROD_W'(k1);
		end
		if (cmd.emit_sample) begin
			pcm_q <= d_w[SAMPLE_W-1:0];
			has_q <= 1'b1;
			last_q <= cmd.last;
		end else if (cmd.emit_end) begin
			pcm_q <= '0;
			has_q <= 1'b0;
			last_q <= 1'b1;
		end
	end

	// Predictor history and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			prev2_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_hist) begin
				prev_q  <= '0;
				prev2_q <= '0;
			end else if (cmd.acc_en) begin
				prev2_q <= prev_q;
				prev_q  <= h_sat;
			end
			if (cmd.emit_sample || cmd.emit_end) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign pcm_sample = pcm_q;
	assign has_sample = has_q;
	assign last       = last_q;

endmodule

`default_nettype wire

// ----- rtl/adpcm_vag_stream_decoder_top.sv -----
// Top level of the VAG ADPCM stream decoder.
`default_nettype none

// The decoder takes a VAG stream one byte per input transfer, skips the first 16 bytes and
// then parses 16-byte blocks (filter/shift byte, flags byte, 14 data bytes); every data byte
// yields two 16-bit samples, low nibble first. Header, flags and skipped bytes are taken in
// the idle state alone. A data byte is taken in the idle state, then for each nibble the
// sequencer steps through a multiply state, an accumulate state and a state that loads the
// output register once it is free; the predictor history feeding the next nibble sets that
// sequence. An end marker (has_sample low, last high) is loaded by the end state after its
// flags byte. The block accepts one byte at a time; the output register holds a result
// while the next byte is taken. source_length may only be written while the decoder is idle.
module adpcm_vag_stream_decoder_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Input byte channel
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [avag_pkg::BYTE_W-1:0]          data_byte,
	input  wire logic                                 stream_start,
	// Sample output channel
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [avag_pkg::SAMPLE_W-1:0]      pcm_sample,
	output logic                                      has_sample,
	output logic                                      last,
	// source_length write channel
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [avag_pkg::COUNT_W-1:0]         cfg_data
);
	import avag_pkg::*;

	avag_cmd_t cmd;
	avag_sts_t sts;

	// Parser and sequencer
	avag_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.stream_start (stream_start),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts)
	);

	// Predictor and output register
	avag_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pcm_sample (pcm_sample),
		.has_sample (has_sample),
		.last       (last)
	);

endmodule

`default_nettype wire
